// ----- sv/bcms_pkg.sv -----
// Package: constants, types and address helpers for the blocked count-min sketch.
`timescale 1ns / 1ps

package bcms_pkg;

	localparam int unsigned BLOCKS = 64;
	localparam int unsigned WINDOW = 5120;

	localparam int unsigned HASH_W  = 64;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned ORDER_W = 2;
	localparam int unsigned ROWS    = 4;

	// floor(log2(BLOCKS)), capped at 20 hash bits
	function automatic int unsigned flog2(input longint unsigned v);
		int unsigned b;
		b = 0;
		while (b < 20 && (64'd1 << (b + 1)) <= v)
			b++;
		return b;
	endfunction

	localparam int unsigned BLK_BITS   = flog2(BLOCKS);
	// each bank holds one row of every block: two 64-bit words per block
	localparam int unsigned ADDR_W     = BLK_BITS + 1;
	localparam int unsigned BANK_DEPTH = 2 ** ADDR_W;
	localparam int unsigned WORD_W     = 64;
	localparam int unsigned NIB_IDX_W  = 4;
	localparam int unsigned SAMPLE_W   = $clog2(WINDOW + 1);
	localparam int unsigned QDEPTH     = 2;

	localparam logic [HASH_W-1:0]  BLK_MASK    = (64'd1 << BLK_BITS) - 64'd1;
	localparam logic [WORD_W-1:0]  HALVE_MASK  = 64'h7777_7777_7777_7777;
	localparam logic [COUNT_W-1:0] COUNTER_MAX = 4'd15;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD     = 2'd0,
		CMD_QUERY   = 2'd1,
		CMD_COMPARE = 2'd2,
		CMD_RSVD    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_QUERY,
		OP_COMPARE
	} op_t;

	typedef enum logic [ORDER_W-1:0] {
		ORD_LESS    = 2'd0,
		ORD_EQUAL   = 2'd1,
		ORD_GREATER = 2'd2
	} order_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_AGE
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [HASH_W-1:0] hash;
		logic [HASH_W-1:0] other_hash;
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [ORDER_W-1:0] order;
	} rsp_t;

	typedef struct packed {
		op_t               op;
		logic [HASH_W-1:0] hash;
		logic [HASH_W-1:0] other_hash;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

	function automatic logic [4:0] row_sel(input logic [HASH_W-1:0] h, input int unsigned r);
		return 5'(h >> (BLK_BITS + 5 * r));
	endfunction

	// bank address: block index, then which of the row's two words
	function automatic logic [ADDR_W-1:0] row_addr(input logic [HASH_W-1:0] h,
			input int unsigned r);
		logic [4:0] sel;
		sel = row_sel(h, r);
		return ADDR_W'({h & BLK_MASK, sel[3]});
	endfunction

	// nibble position within the word: byte in word, then high/low nibble
	function automatic logic [NIB_IDX_W-1:0] row_nib(input logic [HASH_W-1:0] h,
			input int unsigned r);
		logic [4:0] sel;
		sel = row_sel(h, r);
		return {sel[2:0], sel[4]};
	endfunction

endpackage

// ----- sv/bcms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bcms_ram #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- sv/bcms_front.sv -----
// Front end: takes requests, decodes the command, and queues them for the back end.
`timescale 1ns / 1ps

module bcms_front import bcms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       request,
	input  back_stat_t stat,
	output head_t      head
);

	localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	item_t            queue_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             push;
	item_t            item_in;

	assign busy = (fill_q == CNT_W'(QDEPTH)) || stat.clearing;
	assign push = start && !busy;

	always_comb begin
		item_in.hash       = request.hash;
		item_in.other_hash = request.other_hash;
		unique case (cmd_t'(request.command)) inside
			CMD_ADD:             item_in.op = OP_ADD;
			CMD_COMPARE:         item_in.op = OP_COMPARE;
			CMD_QUERY, CMD_RSVD: item_in.op = OP_QUERY;
			default:             item_in.op = OP_QUERY;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (stat.pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !stat.pop)
				fill_q <= fill_q + 1'b1;
			else if (!push && stat.pop)
				fill_q <= fill_q - 1'b1;
		end
	end

	assign head.valid = (fill_q != '0);
	assign head.item  = queue_q[rd_ptr_q];

endmodule

// ----- sv/bcms_back.sv -----
// Back end: counter banks, read-modify-write sequencer, clear and aging sweeps.
`timescale 1ns / 1ps

module bcms_back import bcms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  head_t      head,
	output back_stat_t stat,
	output logic       done,
	output rsp_t       result
);

	state_t               state_q, state_d;
	logic [ADDR_W:0]      sweep_q, sweep_d;
	logic [SAMPLE_W-1:0]  sample_q, sample_d;
	logic [SAMPLE_W-1:0]  sample_inc;
	item_t                item_q;
	logic                 load_item;
	logic [COUNT_W-1:0]   cnt_a_q;
	logic                 load_cnt_a;
	logic                 done_q, done_d;
	rsp_t                 result_q, result_d;

	logic                 re;
	logic                 we;
	logic [ADDR_W-1:0]    raddr [ROWS];
	logic [ADDR_W-1:0]    waddr [ROWS];
	logic [WORD_W-1:0]    wdata [ROWS];
	logic [WORD_W-1:0]    rdata [ROWS];
	logic [WORD_W-1:0]    upd_word [ROWS];
	logic [COUNT_W-1:0]   old_nib [ROWS];
	logic [COUNT_W-1:0]   new_nib [ROWS];
	logic [HASH_W-1:0]    sel_hash;
	logic [COUNT_W-1:0]   min_old, min_new;

	for (genvar r = 0; r < ROWS; r++) begin : g_bank
		bcms_ram #(
			.DEPTH(BANK_DEPTH),
			.WIDTH(WORD_W)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(waddr[r]),
			.wdata(wdata[r]),
			.re   (re),
			.raddr(raddr[r]),
			.rdata(rdata[r])
		);
	end

	// second read of a compare looks at the right-side hash
	assign sel_hash = (state_q == ST_RD2) ? item_q.other_hash : item_q.hash;

	always_comb begin
		min_old = COUNTER_MAX;
		min_new = COUNTER_MAX;
		for (int unsigned r = 0; r < ROWS; r++) begin
			old_nib[r]  = rdata[r][row_nib(sel_hash, r)*COUNT_W +: COUNT_W];
			new_nib[r]  = (old_nib[r] == COUNTER_MAX) ? COUNTER_MAX : old_nib[r] + 1'b1;
			upd_word[r] = rdata[r];
			upd_word[r][row_nib(sel_hash, r)*COUNT_W +: COUNT_W] = new_nib[r];
			if (old_nib[r] < min_old)
				min_old = old_nib[r];
			if (new_nib[r] < min_new)
				min_new = new_nib[r];
		end
	end

	assign sample_inc = sample_q + 1'b1;

	always_comb begin
		state_d       = state_q;
		sweep_d       = sweep_q;
		sample_d      = sample_q;
		load_item     = 1'b0;
		load_cnt_a    = 1'b0;
		done_d        = 1'b0;
		result_d      = result_q;
		stat.pop      = 1'b0;
		stat.clearing = (state_q == ST_CLEAR);
		re            = 1'b0;
		we            = 1'b0;
		for (int unsigned r = 0; r < ROWS; r++) begin
			raddr[r] = row_addr(head.item.hash, r);
			waddr[r] = row_addr(item_q.hash, r);
			wdata[r] = upd_word[r];
		end
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				for (int unsigned r = 0; r < ROWS; r++) begin
					waddr[r] = sweep_q[ADDR_W-1:0];
					wdata[r] = '0;
				end
				sweep_d = sweep_q + 1'b1;
				if (sweep_q[ADDR_W-1:0] == ADDR_W'(BANK_DEPTH - 1)) begin
					sweep_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head.valid) begin
					stat.pop  = 1'b1;
					load_item = 1'b1;
					re        = 1'b1;
					state_d   = ST_RD1;
				end
			end
			ST_RD1: begin
				unique case (item_q.op)
					OP_ADD: begin
						we       = 1'b1;
						done_d   = 1'b1;
						result_d = '{count: min_new, order: ORD_EQUAL};
						if (sample_inc >= SAMPLE_W'(WINDOW)) begin
							sample_d = sample_inc >> 1;
							sweep_d  = '0;
							state_d  = ST_AGE;
						end else begin
							sample_d = sample_inc;
							state_d  = ST_IDLE;
						end
					end
					OP_COMPARE: begin
						load_cnt_a = 1'b1;
						re         = 1'b1;
						for (int unsigned r = 0; r < ROWS; r++)
							raddr[r] = row_addr(item_q.other_hash, r);
						state_d = ST_RD2;
					end
					default: begin
						done_d   = 1'b1;
						result_d = '{count: min_old, order: ORD_EQUAL};
						state_d  = ST_IDLE;
					end
				endcase
			end
			ST_RD2: begin
				done_d         = 1'b1;
				result_d.count = cnt_a_q;
				if (cnt_a_q < min_old)
					result_d.order = ORD_LESS;
				else if (cnt_a_q > min_old)
					result_d.order = ORD_GREATER;
				else
					result_d.order = ORD_EQUAL;
				state_d = ST_IDLE;
			end
			ST_AGE: begin
				// read word k while writing back the halved word k-1
				re = !sweep_q[ADDR_W];
				we = (sweep_q != '0);
				for (int unsigned r = 0; r < ROWS; r++) begin
					raddr[r] = sweep_q[ADDR_W-1:0];
					waddr[r] = ADDR_W'(sweep_q - 1'b1);
					wdata[r] = (rdata[r] >> 1) & HALVE_MASK;
				end
				sweep_d = sweep_q + 1'b1;
				if (sweep_q[ADDR_W]) begin
					sweep_d = '0;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			sweep_q  <= '0;
			sample_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			sweep_q  <= sweep_d;
			sample_q <= sample_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_item)
			item_q <= head.item;
		if (load_cnt_a)
			cnt_a_q <= min_old;
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- sv/blocked_count_min_sketch.sv -----
// Top level of the blocked count-min frequency sketch.
//
// Usage:
//   A request (command, hash, other_hash) is taken at a rising edge where
//   start is high and busy is low. Commands: add (raise the four counters of
//   hash, saturating at 15), query (read only; the unused code also acts as
//   a query), compare (order the minimums of hash and other_hash).
//   Every request yields exactly one result, shown on result for a single
//   cycle with done high. The receiver cannot stall; results must be taken.
// Flow:
//   Requests land in a two-entry queue; the back end reads the four banks
//   once per hash and writes them back on an add. Add and query pass through
//   the read state RD1, compare through RD1 and then RD2, from leaving the
//   queue to done. The back end serves one request at a time and pops the
//   next only once it is back in idle.
//   When the sample count reaches the window, a halving sweep runs over all
//   counter words, during which no request is served; the queue keeps
//   taking requests until it fills.
// Reset:
//   arst_n clears control state, then a clearing pass zeroes every counter,
//   one word per bank per cycle. busy stays high during that pass.
`timescale 1ns / 1ps

module blocked_count_min_sketch import bcms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	head_t      head;
	back_stat_t stat;

	// request intake and decode, queue toward the back end
	bcms_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.stat   (stat),
		.head   (head)
	);

	// counter banks and sequencer
	bcms_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.stat  (stat),
		.done  (done),
		.result(result)
	);

endmodule

// ----- sv/bcms_check.sv -----
// Port-level checker for the sketch, bound to the top level.
`timescale 1ns / 1ps

module bcms_check import bcms_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t result
);

	// each request passes through idle and at least one read state in the back end
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on consecutive cycles");

	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.order == ORD_LESS || result.order == ORD_EQUAL
			|| result.order == ORD_GREATER))
		else $error("order code out of range");

	a_less_not_max: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.order == ORD_LESS) |-> (result.count != COUNTER_MAX))
		else $error("less with left count at maximum");

	a_greater_not_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.order == ORD_GREATER) |-> (result.count != '0))
		else $error("greater with left count zero");

	// clearing pass holds off requests right after reset
	a_busy_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> busy)
		else $error("not busy right after reset");

endmodule

bind blocked_count_min_sketch bcms_check u_bcms_check (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the blocked count-min frequency sketch.
`timescale 1ns / 1ps

module tb_top;
	import bcms_pkg::*;

	// Scoreboard: keeps its own copy of the counter store and the add
	// counter, works out the response of every accepted request and checks
	// the responses in order.
	class sketch_scoreboard;
		logic [WORD_W-1:0] words [BLOCKS*8];
		int unsigned       samples;
		rsp_t              pending_rsp [$];
		int unsigned       errors, halvings, saturated;
		int unsigned       n_add, n_query, n_compare, n_rsvd;

		function new();
			foreach (words[i]) words[i] = '0;
			samples   = 0;
			errors    = 0;
			halvings  = 0;
			saturated = 0;
			n_add     = 0;
			n_query   = 0;
			n_compare = 0;
			n_rsvd    = 0;
		endfunction

		// word index and bit offset of the row r counter that h selects
		function void find_counter(input logic [HASH_W-1:0] h, input int unsigned r,
				output int unsigned widx, output int unsigned pos);
			logic [HASH_W-1:0] rest;
			logic [4:0]        sel;
			int unsigned       byte_idx;
			rest     = h >> BLK_BITS;
			sel      = 5'(rest >> (5 * r));
			byte_idx = 16 * r + sel[3:0];
			widx     = int'(h & BLK_MASK) * 8 + byte_idx / 8;
			pos      = (byte_idx % 8) * 8 + sel[4] * 4;
		endfunction

		function logic [COUNT_W-1:0] min_count(input logic [HASH_W-1:0] h);
			logic [COUNT_W-1:0] m;
			logic [COUNT_W-1:0] v;
			int unsigned        w;
			int unsigned        p;
			m = COUNTER_MAX;
			for (int unsigned r = 0; r < ROWS; r++) begin
				find_counter(h, r, w, p);
				v = words[w][p +: COUNT_W];
				if (v < m) m = v;
			end
			return m;
		endfunction

		// saturating bump of the four counters, then aging once the window fills
		function logic [COUNT_W-1:0] add_key(input logic [HASH_W-1:0] h);
			logic [COUNT_W-1:0] m;
			logic [COUNT_W-1:0] v;
			int unsigned        w;
			int unsigned        p;
			m = COUNTER_MAX;
			for (int unsigned r = 0; r < ROWS; r++) begin
				find_counter(h, r, w, p);
				v = words[w][p +: COUNT_W];
				if (v != COUNTER_MAX) v++;
				words[w][p +: COUNT_W] = v;
				if (v < m) m = v;
			end
			samples++;
			if (samples >= WINDOW) begin
				foreach (words[i]) words[i] = (words[i] >> 1) & HALVE_MASK;
				samples = samples / 2;
				halvings++;
			end
			return m;
		endfunction

		function void note_request(input req_t rq);
			rsp_t               want;
			logic [COUNT_W-1:0] rhs;
			want.order = ORD_EQUAL;
			case (cmd_t'(rq.command))
				CMD_ADD: begin
					want.count = add_key(rq.hash);
					n_add++;
					if (want.count == COUNTER_MAX) saturated++;
				end
				CMD_COMPARE: begin
					want.count = min_count(rq.hash);
					rhs        = min_count(rq.other_hash);
					if (want.count < rhs)      want.order = ORD_LESS;
					else if (want.count > rhs) want.order = ORD_GREATER;
					n_compare++;
				end
				default: begin
					// the spare code reads like a query
					want.count = min_count(rq.hash);
					if (rq.command == CMD_RSVD) n_rsvd++;
					else n_query++;
				end
			endcase
			pending_rsp.push_back(want);
		endfunction

		function void check_result(input rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				$display("%0t: response count=%0d order=%0d with no request outstanding",
					$time, got.count, got.order);
				errors++;
				return;
			end
			want = pending_rsp.pop_front();
			if (got.count !== want.count) begin
				$display("%0t: count mismatch: expected %0d, actual %0d",
					$time, want.count, got.count);
				errors++;
			end
			if (got.order !== want.order) begin
				$display("%0t: order mismatch: expected %0d, actual %0d",
					$time, want.order, got.order);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	rsp_t result;

	sketch_scoreboard  sb = new();
	logic [HASH_W-1:0] hot_keys [8];

	blocked_count_min_sketch i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: well beyond the slowest legal run (about 1.9k requests plus
	// idle gaps, and the clearing pass).
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Monitor. Both handshakes are sampled at the clock edge, so the values
	// seen are the ones settled before the edge. A request taken and a
	// response shown on the same edge never belong together (the response
	// is always from an older request), so noting first is safe.
	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_request(request);
		if (arst_n && done) sb.check_result(result);
	end

	function automatic logic [HASH_W-1:0] rand_hash();
		return {$urandom, $urandom};
	endfunction

	// Hash source: half from a small hot set so counters climb to saturation
	// and compares see unequal minimums, half fully random.
	function automatic logic [HASH_W-1:0] pick_hash();
		if ($urandom_range(0, 1) == 0) return hot_keys[$urandom_range(0, 7)];
		return rand_hash();
	endfunction

	function automatic req_t make_req(input int unsigned add_pct);
		req_t        rq;
		int unsigned roll;
		rq.hash       = pick_hash();
		rq.other_hash = pick_hash();
		roll          = $urandom_range(0, 99);
		if (roll < add_pct) begin
			rq.command = CMD_ADD;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 40)      rq.command = CMD_QUERY;
			else if (roll < 85) rq.command = CMD_COMPARE;
			else                rq.command = CMD_RSVD;
		end
		return rq;
	endfunction

	// Hold the request up until it is taken. start stays high on return so
	// back-to-back calls form a burst with no bubble.
	task automatic send_request(input req_t rq);
		start   <= 1'b1;
		request <= rq;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Sender idle gap; n is at least one, so start never sees two updates
	// in one step.
	task automatic idle_gap(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_cmd(input cmd_t c, input logic [HASH_W-1:0] h,
			input logic [HASH_W-1:0] o);
		req_t rq;
		rq.command    = c;
		rq.hash       = h;
		rq.other_hash = o;
		send_request(rq);
	endtask

	// Bursts of random length with random gaps; an occasional long burst
	// keeps the request queue full. With until_aged set it keeps going
	// until the store has aged twice.
	task automatic run_bursts(input int unsigned n_items, input int unsigned add_pct,
			input bit until_aged);
		int unsigned issued;
		int unsigned burst;
		issued = 0;
		while (issued < n_items || (until_aged && sb.halvings < 2)) begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
			repeat (burst) begin
				send_request(make_req(add_pct));
				issued++;
			end
			idle_gap($urandom_range(1, 6));
		end
	endtask

	localparam logic [HASH_W-1:0] ALL_ONES  = '1;
	localparam logic [HASH_W-1:0] HIGH_ONLY = 64'hFFFF_FFFF_FC00_0000;

	initial begin
		int unsigned wait_cycles;
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		hot_keys[0] = '0;
		hot_keys[1] = ALL_ONES;
		for (int i = 2; i < 8; i++) hot_keys[i] = rand_hash();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: fresh store, field extremes, every command, the spare
		// code, hash bits above the used range, block bits alone.
		// busy covers the clearing pass, so no wait is needed here.
		send_cmd(CMD_QUERY,   '0,        ALL_ONES);
		send_cmd(CMD_ADD,     '0,        ALL_ONES);
		send_cmd(CMD_ADD,     '0,        '0);
		send_cmd(CMD_ADD,     ALL_ONES,  '0);
		send_cmd(CMD_QUERY,   ALL_ONES,  '0);
		send_cmd(CMD_COMPARE, '0,        ALL_ONES);
		send_cmd(CMD_COMPARE, ALL_ONES,  '0);
		send_cmd(CMD_COMPARE, '0,        '0);
		send_cmd(CMD_RSVD,    '0,        ALL_ONES);
		// only unused upper bits set: lands on the same counters as zero
		send_cmd(CMD_ADD,     HIGH_ONLY, ALL_ONES);
		send_cmd(CMD_QUERY,   '0,        '0);
		// last block, all row selects zero
		send_cmd(CMD_ADD,     64'h3F,    '0);
		send_cmd(CMD_QUERY,   64'h3F,    ALL_ONES);
		send_cmd(CMD_ADD,     64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_cmd(CMD_ADD,     64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_cmd(CMD_COMPARE, 64'h5555_5555_5555_5555, 64'h3F);
		send_cmd(CMD_COMPARE, 64'h3F,    HIGH_ONLY);
		send_cmd(CMD_RSVD,    ALL_ONES,  '0);
		idle_gap(3);

		// Random mix, then add-heavy traffic to drive hot counters into
		// saturation, then a short mixed tail.
		run_bursts(1500, 50, 1'b0);
		run_bursts(250, 90, 1'b0);
		run_bursts(150, 50, 1'b0);

		wait_cycles = 0;
		while (sb.pending_rsp.size() != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		// leave a little slack for stray strobes
		repeat (10) @(posedge clk);

		$display("Requests: %0d add, %0d query, %0d compare, %0d spare-code",
			sb.n_add, sb.n_query, sb.n_compare, sb.n_rsvd);
		$display("Aging sweeps: %0d, adds returning a saturated count: %0d",
			sb.halvings, sb.saturated);
		if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
			$display("PASS");
		end else begin
			if (sb.pending_rsp.size() != 0)
				$display("%0t: %0d responses never arrived", $time, sb.pending_rsp.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
